@@ sv/bmf_pkg.sv @@
// Shared types, constants and the neighbourhood sum for the 3x3 box mean filter.
`timescale 1ns / 1ps

package bmf_pkg;

  // Image size defaults
  localparam int IMAGE_WIDTH_DEF  = 64;
  localparam int IMAGE_HEIGHT_DEF = 64;

  // Pixel and result widths
  localparam int PIX_W     = 8;
  localparam int POS_W     = 6;
  localparam int NEIGHBORS = 9;
  localparam int SUM_W     = 12;
  localparam int DATA_W    = 24;

  // Divide by nine as multiply by reciprocal and shift
  localparam int MUL_SHIFT = 16;
  localparam int RECIP     = ((2 ** MUL_SHIFT) + NEIGHBORS - 1) / NEIGHBORS;
  localparam int RECIP_W   = 13;
  localparam int PROD_W    = SUM_W + RECIP_W;

  // Rows held in one column cell
  localparam int ROW_UP  = 0;
  localparam int ROW_MID = 1;
  localparam int ROW_CUR = 2;
  localparam int WIN     = 3;

  // Result slots raised by one input pixel
  localparam int NUM_RES            = 4;
  localparam int SLOT_PREV_ROW_BACK = 0;
  localparam int SLOT_PREV_ROW_EDGE = 1;
  localparam int SLOT_CUR_ROW_BACK  = 2;
  localparam int SLOT_CUR_ROW_EDGE  = 3;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [WIN-1:0]   column_t;
  typedef column_t [WIN-1:0] win_t;
  typedef logic [SUM_W-1:0] sum_t;

  // Entry of the row store: row r-1 and row r-2 at one column
  typedef struct packed {
    pix_t mid;
    pix_t up;
  } store_t;

  // Position information carried with a pixel
  typedef struct packed {
    logic             left1;
    logic             left2;
    logic             last_col;
    logic             row1;
    logic             row2;
    logic             last_row;
    logic [POS_W-1:0] col6;
    logic [POS_W-1:0] row6;
  } meta_t;

  // Sums and positions handed to the result sequencer
  typedef struct packed {
    sum_t [NUM_RES-1:0] sum;
    logic [NUM_RES-1:0] mask;
    logic [POS_W-1:0]   col6;
    logic [POS_W-1:0]   row6;
    logic               frame;
  } res_t;

  // Sum of nine values; a missing row or column takes the centre value
  function automatic sum_t box_sum(win_t w, logic [WIN-1:0] rv, logic [WIN-1:0] cv);
    sum_t acc;
    pix_t center;
    acc    = '0;
    center = w[1][1];
    for (int i = 0; i < WIN; i++) begin
      for (int j = 0; j < WIN; j++) begin
        if (rv[i] && cv[j]) begin
          acc = acc + SUM_W'(w[i][j]);
        end else begin
          acc = acc + SUM_W'(center);
        end
      end
    end
    return acc;
  endfunction

endpackage

@@ sv/bmf_line_store.sv @@
// Row store holding the two previous rows, one entry per column.
`timescale 1ns / 1ps

module bmf_line_store #(
  parameter int DEPTH = bmf_pkg::IMAGE_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output bmf_pkg::store_t          rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  bmf_pkg::store_t          wr_data
);

  bmf_pkg::store_t mem [DEPTH];
  bmf_pkg::store_t rd_data_r;

  // Write the rotated column, read the next column ahead of its use
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/bmf_cell.sv @@
// One column cell of the 3x3 window; passes its column to the next cell on a shift.
`timescale 1ns / 1ps

module bmf_cell (
  input  logic             clk,
  input  logic             shift_en,
  input  bmf_pkg::column_t col_in,
  output bmf_pkg::column_t col_out
);

  bmf_pkg::column_t col_r;

  // Take the neighbour's column when the window advances
  always_ff @(posedge clk) begin
    if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;

endmodule

@@ sv/bmf_emit.sv @@
// Result sequencer: holds up to four sums of one pixel and sends them out one beat each.
`timescale 1ns / 1ps

module bmf_emit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load_valid,
  input  bmf_pkg::res_t                load,
  output logic                         load_ready,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [bmf_pkg::DATA_W-1:0]   out_tdata,
  output logic                         out_tlast,
  output logic                         out_tuser
);

  logic [bmf_pkg::NUM_RES-1:0] pend_r, pend_nxt;
  bmf_pkg::res_t               res_r;
  logic                        out_v_r, out_v_nxt;
  logic [bmf_pkg::PIX_W-1:0]   mean_r;
  logic [bmf_pkg::POS_W-1:0]   col_r, row_r;
  logic                        last_r, done_r;

  logic [1:0]                  idx;
  logic [bmf_pkg::NUM_RES-1:0] rest;
  logic                        out_load;
  logic                        take;
  logic [bmf_pkg::PROD_W-1:0]  prod;
  logic [bmf_pkg::POS_W-1:0]   col_sel, row_sel;

  // Pick the lowest pending slot
  always_comb begin
    idx = 2'(bmf_pkg::SLOT_CUR_ROW_EDGE);
    if (pend_r[bmf_pkg::SLOT_PREV_ROW_BACK]) begin
      idx = 2'(bmf_pkg::SLOT_PREV_ROW_BACK);
    end else if (pend_r[bmf_pkg::SLOT_PREV_ROW_EDGE]) begin
      idx = 2'(bmf_pkg::SLOT_PREV_ROW_EDGE);
    end else if (pend_r[bmf_pkg::SLOT_CUR_ROW_BACK]) begin
      idx = 2'(bmf_pkg::SLOT_CUR_ROW_BACK);
    end
  end

  assign rest       = pend_r & ~(bmf_pkg::NUM_RES'(1) << idx);
  assign out_load   = (pend_r != '0) && (!out_v_r || out_tready);
  assign load_ready = (pend_r == '0) || (out_load && (rest == '0));
  assign take       = load_valid && load_ready;

  // Position of the selected result
  always_comb begin
    case (idx)
      2'(bmf_pkg::SLOT_PREV_ROW_BACK): begin
        col_sel = res_r.col6 - bmf_pkg::POS_W'(1);
        row_sel = res_r.row6 - bmf_pkg::POS_W'(1);
      end
      2'(bmf_pkg::SLOT_PREV_ROW_EDGE): begin
        col_sel = res_r.col6;
        row_sel = res_r.row6 - bmf_pkg::POS_W'(1);
      end
      2'(bmf_pkg::SLOT_CUR_ROW_BACK): begin
        col_sel = res_r.col6 - bmf_pkg::POS_W'(1);
        row_sel = res_r.row6;
      end
      default: begin
        col_sel = res_r.col6;
        row_sel = res_r.row6;
      end
    endcase
  end

  // Divide the selected sum by nine
  assign prod = bmf_pkg::PROD_W'(res_r.sum[idx]) *
                bmf_pkg::PROD_W'(bmf_pkg::RECIP);

  // Next pending mask and output valid
  always_comb begin
    pend_nxt = pend_r;
    if (take) begin
      pend_nxt = load.mask;
    end else if (out_load) begin
      pend_nxt = rest;
    end
    out_v_nxt = out_v_r;
    if (out_load) begin
      out_v_nxt = 1'b1;
    end else if (out_tready) begin
      out_v_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      pend_r  <= pend_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Payload: hold the pixel's sums, load the output beat
  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= load;
    end
    if (out_load) begin
      mean_r <= prod[bmf_pkg::MUL_SHIFT +: bmf_pkg::PIX_W];
      col_r  <= col_sel;
      row_r  <= row_sel;
      last_r <= (rest == '0);
      done_r <= (rest == '0) && res_r.frame;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(bmf_pkg::DATA_W - bmf_pkg::PIX_W - 2 * bmf_pkg::POS_W){1'b0}},
                       row_r, col_r, mean_r};
  assign out_tlast  = last_r;
  assign out_tuser  = done_r;

endmodule

@@ sv/box_mean_filter_3x3.sv @@
// Top level of the 3x3 box mean filter over a raster image.
//
//  channel  dir  tdata (low bit up)                          tlast     tuser
//  in_      in   pixel[7:0]                                  -         -
//  out_     out  mean_value[7:0] out_column[13:8]            run_last  frame_done
//                out_row[19:14], zero [23:20]
//
// One pixel per clock while out_ is ready and each pixel raises at most one result; a
// pixel that raises several results holds the result sequencer until all are sent (two
// at the right edge, two along the last row, four for the final pixel). A pixel passes
// row store read, window cell shift, sum and divide into the output register before its
// first result beat. Reset clears the position counters and all stage valids; the row
// stores are not cleared. A stall on out_ fills the stages and then drops in_tready.
`timescale 1ns / 1ps

module box_mean_filter_3x3 #(
  parameter int IMAGE_WIDTH  = bmf_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = bmf_pkg::IMAGE_HEIGHT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // pixel[7:0]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [bmf_pkg::DATA_W-1:0] out_tdata,  // mean_value, out_column, out_row, pad
  output logic                       out_tlast,
  output logic                       out_tuser   // frame_done
);

  localparam int CW = $clog2(IMAGE_WIDTH);
  localparam int RW = $clog2(IMAGE_HEIGHT);

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          acc;
  logic          last_col_now, last_row_now;
  bmf_pkg::meta_t meta_in;

  logic           s1_v_r, s1_v_nxt;
  bmf_pkg::pix_t  s1_pix_r;
  logic [CW-1:0]  s1_addr_r;
  bmf_pkg::meta_t s1_meta_r;
  logic           s1_move;

  logic           s2_v_r, s2_v_nxt;
  bmf_pkg::meta_t s2_meta_r;
  logic           s2_free;
  logic           s3_free;
  logic           s3_take;

  bmf_pkg::store_t  rd_data;
  bmf_pkg::store_t  wr_data;
  bmf_pkg::column_t col_new;
  bmf_pkg::column_t cell_col [bmf_pkg::WIN];
  bmf_pkg::res_t    res;

  bmf_pkg::win_t    w_prev_back, w_prev_edge, w_cur_back, w_cur_edge;
  logic [bmf_pkg::WIN-1:0] rv_prev, rv_cur, cv_back, cv_edge;

  assign acc          = in_tvalid && in_tready;
  assign last_col_now = (col_r == CW'(IMAGE_WIDTH - 1));
  assign last_row_now = (row_r == RW'(IMAGE_HEIGHT - 1));

  // Position of the next pixel
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (last_col_now) begin
        col_nxt = '0;
        row_nxt = last_row_now ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  // Border flags of the accepted pixel
  always_comb begin
    meta_in.left1    = (col_r != '0);
    meta_in.left2    = (col_r >= CW'(2));
    meta_in.last_col = last_col_now;
    meta_in.row1     = (row_r != '0);
    meta_in.row2     = (row_r >= RW'(2));
    meta_in.last_row = last_row_now;
    meta_in.col6     = bmf_pkg::POS_W'(col_r);
    meta_in.row6     = bmf_pkg::POS_W'(row_r);
  end

  // Stage handshakes
  assign s3_take   = s2_v_r && s3_free;
  assign s2_free   = !s2_v_r || s3_take;
  assign s1_move   = s1_v_r && s2_free;
  assign in_tready = !s1_v_r || s1_move;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (acc) begin
      s1_v_nxt = 1'b1;
    end else if (s1_move) begin
      s1_v_nxt = 1'b0;
    end
    s2_v_nxt = s2_v_r;
    if (s1_move) begin
      s2_v_nxt = 1'b1;
    end else if (s3_take) begin
      s2_v_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r  <= in_tdata;
      s1_addr_r <= col_r;
      s1_meta_r <= meta_in;
    end
    if (s1_move) begin
      s2_meta_r <= s1_meta_r;
    end
  end

  // Rotate rows in the store: current row becomes middle, middle becomes upper
  assign wr_data.mid = s1_pix_r;
  assign wr_data.up  = rd_data.mid;

  bmf_line_store #(
    .DEPTH (IMAGE_WIDTH)
  ) u_store (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (col_r),
    .rd_data (rd_data),
    .wr_en   (s1_move),
    .wr_addr (s1_addr_r),
    .wr_data (wr_data)
  );

  // New column entering the window
  always_comb begin
    col_new                   = '0;
    col_new[bmf_pkg::ROW_UP]  = rd_data.up;
    col_new[bmf_pkg::ROW_MID] = rd_data.mid;
    col_new[bmf_pkg::ROW_CUR] = s1_pix_r;
  end

  // Chain of window cells: cell 0 holds column c, cell 2 holds column c-2
  for (genvar k = 0; k < bmf_pkg::WIN; k++) begin : g_cell
    bmf_cell u_cell (
      .clk      (clk),
      .shift_en (s1_move),
      .col_in   ((k == 0) ? col_new : cell_col[(k == 0) ? 0 : k - 1]),
      .col_out  (cell_col[k])
    );
  end

  // Arrange the four neighbourhoods from the window cells
  always_comb begin
    for (int i = 0; i < bmf_pkg::WIN; i++) begin
      w_prev_back[i][0] = cell_col[2][i];
      w_prev_back[i][1] = cell_col[1][i];
      w_prev_back[i][2] = cell_col[0][i];
      w_prev_edge[i][0] = cell_col[1][i];
      w_prev_edge[i][1] = cell_col[0][i];
      w_prev_edge[i][2] = cell_col[0][i];
    end
    for (int j = 0; j < bmf_pkg::WIN; j++) begin
      w_cur_back[0][j] = w_prev_back[bmf_pkg::ROW_MID][j];
      w_cur_back[1][j] = w_prev_back[bmf_pkg::ROW_CUR][j];
      w_cur_back[2][j] = w_prev_back[bmf_pkg::ROW_CUR][j];
      w_cur_edge[0][j] = w_prev_edge[bmf_pkg::ROW_MID][j];
      w_cur_edge[1][j] = w_prev_edge[bmf_pkg::ROW_CUR][j];
      w_cur_edge[2][j] = w_prev_edge[bmf_pkg::ROW_CUR][j];
    end
    rv_prev = {2'b11, s2_meta_r.row2};
    rv_cur  = 3'b011;
    cv_back = {2'b11, s2_meta_r.left2};
    cv_edge = 3'b011;
  end

  // Sums and pending slots of the pixel in the window
  always_comb begin
    res.sum[bmf_pkg::SLOT_PREV_ROW_BACK] = bmf_pkg::box_sum(w_prev_back, rv_prev, cv_back);
    res.sum[bmf_pkg::SLOT_PREV_ROW_EDGE] = bmf_pkg::box_sum(w_prev_edge, rv_prev, cv_edge);
    res.sum[bmf_pkg::SLOT_CUR_ROW_BACK]  = bmf_pkg::box_sum(w_cur_back, rv_cur, cv_back);
    res.sum[bmf_pkg::SLOT_CUR_ROW_EDGE]  = bmf_pkg::box_sum(w_cur_edge, rv_cur, cv_edge);
    res.mask[bmf_pkg::SLOT_PREV_ROW_BACK] = s2_meta_r.row1 && s2_meta_r.left1;
    res.mask[bmf_pkg::SLOT_PREV_ROW_EDGE] = s2_meta_r.row1 && s2_meta_r.last_col;
    res.mask[bmf_pkg::SLOT_CUR_ROW_BACK]  = s2_meta_r.row1 && s2_meta_r.last_row &&
                                            s2_meta_r.left1;
    res.mask[bmf_pkg::SLOT_CUR_ROW_EDGE]  = s2_meta_r.row1 && s2_meta_r.last_row &&
                                            s2_meta_r.last_col;
    res.col6  = s2_meta_r.col6;
    res.row6  = s2_meta_r.row6;
    res.frame = s2_meta_r.last_row && s2_meta_r.last_col;
  end

  bmf_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (s2_v_r),
    .load       (res),
    .load_ready (s3_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

`ifndef ASSERT_OFF
  // A beat at the right edge wraps the column count
  a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && last_col_now) |=> (col_r == '0))
    else $error("column count did not wrap at the right edge");

  // The final pixel of the image restarts the row count
  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && last_col_now && last_row_now) |=> (row_r == '0))
    else $error("row count did not restart after the final pixel");

  // The corner result of the last row comes only with both edge neighbours
  a_corner_slots: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_take && res.mask[bmf_pkg::SLOT_CUR_ROW_EDGE]) |->
      (res.mask[bmf_pkg::SLOT_PREV_ROW_EDGE] && res.mask[bmf_pkg::SLOT_CUR_ROW_BACK]))
    else $error("final pixel without its edge results");

  // End of frame is flagged only on the last beat of a pixel
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("frame end flagged on a beat that is not the last of its pixel");
`endif

endmodule
